// ===== hw/rtl/gtoe_pkg.sv =====
// Shared types and constants for the graph traversal order engine.
package gtoe_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VTX_W        = 4;
	localparam int VCNT_W       = 5;
	localparam int DROP_W       = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_VERTEX   = 2'd2;

	localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = 5'd10;
	localparam logic [DROP_W-1:0] DROP_MAX         = 8'd255;

	typedef struct packed {
		logic [VTX_W-1:0] end_a;
		logic [VTX_W-1:0] end_b;
		logic             has_edge;
		logic             last;
	} in_item_t;

	typedef struct packed {
		logic [VTX_W-1:0]  vertex;
		logic              final_res;
		logic [DROP_W-1:0] dropped_edges;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LINK_B,
		S_LINK_A,
		S_SCAN,
		S_DFS_TOP,
		S_DFS_EDGE,
		S_BFS_POP,
		S_BFS_LIST,
		S_BFS_EDGE,
		S_CLEAR
	} state_t;

	typedef struct packed {
		logic load;
		logic link_b;
		logic link_a;
		logic scan_next;
		logic start_walk;
		logic dfs_read;
		logic dfs_edge;
		logic dfs_pop;
		logic bfs_pop;
		logic bfs_read;
		logic bfs_edge;
		logic flush;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic in_has_edge;
		logic in_last;
		logic edge_bad;
		logic last_q;
		logic mode;
		logic scan_done;
		logic cand_visited;
		logic top_zero;
		logic top_ok;
		logic q_empty;
		logic cur_ok;
		logic rd_visited;
		logic out_busy;
		logic emit_done;
	} sts_t;

endpackage

// ===== hw/rtl/gtoe_ctrl.sv =====
// Sequencing state machine for edge loading and traversal.
module gtoe_ctrl
	import gtoe_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.in_has_edge && !sts.edge_bad)
						state_d = S_LINK_B;
					else if (sts.in_last)
						state_d = S_SCAN;
				end
			end
			S_LINK_B: state_d = S_LINK_A;
			S_LINK_A: state_d = sts.last_q ? S_SCAN : S_IDLE;
			S_SCAN: begin
				if (sts.scan_done) begin
					if (!sts.out_busy)
						state_d = S_CLEAR;
				end else if (!sts.cand_visited && !sts.out_busy)
					state_d = sts.mode ? S_DFS_TOP : S_BFS_POP;
			end
			S_DFS_TOP: begin
				if (sts.top_zero)
					state_d = S_SCAN;
				else if (sts.top_ok)
					state_d = S_DFS_EDGE;
			end
			S_DFS_EDGE: begin
				if (sts.rd_visited || !sts.out_busy)
					state_d = S_DFS_TOP;
			end
			S_BFS_POP:  state_d = sts.q_empty ? S_SCAN : S_BFS_LIST;
			S_BFS_LIST: state_d = sts.cur_ok ? S_BFS_EDGE : S_BFS_POP;
			S_BFS_EDGE: begin
				if (sts.rd_visited || !sts.out_busy)
					state_d = S_BFS_LIST;
			end
			S_CLEAR: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_LINK_B: cmd.link_b = 1'b1;
			S_LINK_A: cmd.link_a = 1'b1;
			S_SCAN: begin
				// last held vertex goes out flagged final once the scan is through
				if (sts.scan_done)
					cmd.flush = !sts.out_busy;
				else if (sts.cand_visited)
					cmd.scan_next = 1'b1;
				else if (!sts.out_busy)
					cmd.start_walk = 1'b1;
			end
			S_DFS_TOP: begin
				if (!sts.top_zero) begin
					cmd.dfs_read = sts.top_ok;
					cmd.dfs_pop  = !sts.top_ok;
				end
			end
			S_DFS_EDGE: cmd.dfs_edge = sts.rd_visited || !sts.out_busy;
			S_BFS_POP:  cmd.bfs_pop = !sts.q_empty;
			S_BFS_LIST: cmd.bfs_read = sts.cur_ok;
			S_BFS_EDGE: cmd.bfs_edge = sts.rd_visited || !sts.out_busy;
			S_CLEAR:    cmd.clear = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/gtoe_dp.sv =====
// Datapath: registers, adjacency lists, edge pool, work store and output register.
module gtoe_dp
	import gtoe_pkg::*;
#(
	parameter int MAX_EDGES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  in_item_t              in_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output out_item_t             out_data,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int POOL = 2 * MAX_EDGES;
	localparam int PW   = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int EW   = VTX_W + PW + 1;
	localparam logic [PW+1:0] POOL_LIM = (PW+2)'(POOL);

	logic [VCNT_W-1:0] vc_q;
	logic              mode_q;
	logic [VTX_W-1:0]  sv_q;

	logic [PW-1:0]       head_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] head_ok_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [EW-1:0]       pool_mem [POOL];
	logic [EW-1:0]       pool_rd_q;
	logic [PW:0]         pool_used_q;
	logic [DROP_W-1:0]   drop_q;

	logic [VTX_W-1:0]    ws_vert_q [MAX_VERTICES];
	logic [PW-1:0]       ws_ptr_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] ws_ok_q;
	logic [VCNT_W-1:0]   top_q, rd_q, wr_q, k_q, emit_q;
	logic [PW-1:0]       cur_p_q;
	logic                cur_ok_q;
	logic [VTX_W-1:0]    a_q, b_q;
	logic                last_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [VTX_W-1:0]    pend_q;
	logic                pend_valid_q;

	logic [VCNT_W-1:0] n_eff, top_m1;
	logic [VTX_W-1:0]  tidx, cand, rd_dest, bfs_u;
	logic [PW-1:0]     rd_next, rd_addr;
	logic              rd_has_next, rd_visited, rd_en, emit, push_out;
	logic [VTX_W-1:0]  emit_vtx;
	logic              edge_bad;
	logic [PW+1:0]     pool_need;

	function automatic logic [VTX_W-1:0] top_free_idx(input logic [VCNT_W-1:0] k);
		logic [VCNT_W-1:0] km1;
		km1 = k - VCNT_W'(1);
		return km1[VTX_W-1:0];
	endfunction

	always_comb begin
		if (vc_q == '0)
			n_eff = VCNT_W'(1);
		else if (vc_q > VCNT_W'(MAX_VERTICES))
			n_eff = VCNT_W'(MAX_VERTICES);
		else
			n_eff = vc_q;
	end

	assign top_m1 = top_q - VCNT_W'(1);
	assign tidx   = top_m1[VTX_W-1:0];
	assign cand   = (k_q == '0) ? ((VCNT_W'(sv_q) < n_eff) ? sv_q : '0)
	                            : top_free_idx(k_q);
	assign {rd_dest, rd_next, rd_has_next} = pool_rd_q;
	assign rd_visited = visited_q[rd_dest];
	assign bfs_u      = ws_vert_q[rd_q[VTX_W-1:0]];

	assign pool_need = (PW+2)'(pool_used_q) + (PW+2)'(2);
	assign edge_bad  = (VCNT_W'(in_data.end_a) >= n_eff) ||
	                   (VCNT_W'(in_data.end_b) >= n_eff) || (pool_need > POOL_LIM);

	assign rd_en   = cmd.dfs_read || cmd.bfs_read;
	assign rd_addr = cmd.dfs_read ? ws_ptr_q[tidx] : cur_p_q;

	assign emit     = cmd.start_walk || ((cmd.dfs_edge || cmd.bfs_edge) && !rd_visited);
	assign emit_vtx = cmd.start_walk ? cand : rd_dest;
	// each visit holds back one vertex, so the final one is known when the scan ends
	assign push_out = emit && pend_valid_q;

	// edge pool: one write port for list links, one registered read for walks
	always_ff @(posedge clk) begin
		if (cmd.link_b)
			pool_mem[pool_used_q[PW-1:0]] <= {a_q, head_q[b_q], head_ok_q[b_q]};
		else if (cmd.link_a)
			pool_mem[pool_used_q[PW-1:0]] <= {b_q, head_q[a_q], head_ok_q[a_q]};
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			pool_rd_q <= pool_mem[rd_addr];
	end

	// list heads, work store payload, edge ends, held vertex and output payload
	always_ff @(posedge clk) begin
		if (cmd.link_b)
			head_q[b_q] <= pool_used_q[PW-1:0];
		if (cmd.link_a)
			head_q[a_q] <= pool_used_q[PW-1:0];
		if (cmd.start_walk) begin
			ws_vert_q[0] <= cand;
			ws_ptr_q[0]  <= head_q[cand];
		end
		if (cmd.dfs_edge) begin
			ws_ptr_q[tidx] <= rd_next;
			if (!rd_visited) begin
				ws_vert_q[top_q[VTX_W-1:0]] <= rd_dest;
				ws_ptr_q[top_q[VTX_W-1:0]]  <= head_q[rd_dest];
			end
		end
		if (cmd.bfs_pop)
			cur_p_q <= head_q[bfs_u];
		if (cmd.bfs_edge) begin
			cur_p_q <= rd_next;
			if (!rd_visited)
				ws_vert_q[wr_q[VTX_W-1:0]] <= rd_dest;
		end
		if (cmd.load) begin
			a_q <= in_data.end_a;
			b_q <= in_data.end_b;
		end
		if (emit)
			pend_q <= emit_vtx;
		if (push_out || cmd.flush) begin
			out_q.vertex        <= pend_q;
			out_q.final_res     <= cmd.flush;
			out_q.dropped_edges <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q         <= VERTEX_COUNT_RST;
			mode_q       <= 1'b0;
			sv_q         <= '0;
			head_ok_q    <= '0;
			visited_q    <= '0;
			pool_used_q  <= '0;
			drop_q       <= '0;
			ws_ok_q      <= '0;
			top_q        <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			k_q          <= '0;
			emit_q       <= '0;
			cur_ok_q     <= 1'b0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VERTEX_COUNT:   vc_q   <= cfg_wdata;
					REG_TRAVERSAL_MODE: mode_q <= cfg_wdata[0];
					REG_START_VERTEX:   sv_q   <= cfg_wdata[VTX_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_q <= in_data.last;
				k_q    <= '0;
				emit_q <= '0;
				if (in_data.has_edge && edge_bad && drop_q != DROP_MAX)
					drop_q <= drop_q + DROP_W'(1);
			end
			if (cmd.link_b) begin
				head_ok_q[b_q] <= 1'b1;
				pool_used_q    <= pool_used_q + (PW+1)'(1);
			end
			if (cmd.link_a) begin
				head_ok_q[a_q] <= 1'b1;
				pool_used_q    <= pool_used_q + (PW+1)'(1);
			end
			if (cmd.scan_next)
				k_q <= k_q + VCNT_W'(1);
			if (cmd.start_walk) begin
				k_q            <= k_q + VCNT_W'(1);
				visited_q[cand] <= 1'b1;
				ws_ok_q[0]     <= head_ok_q[cand];
				top_q          <= VCNT_W'(1);
				rd_q           <= '0;
				wr_q           <= VCNT_W'(1);
			end
			if (cmd.dfs_pop)
				top_q <= top_m1;
			if (cmd.dfs_edge) begin
				ws_ok_q[tidx] <= rd_has_next;
				if (!rd_visited) begin
					visited_q[rd_dest]        <= 1'b1;
					ws_ok_q[top_q[VTX_W-1:0]] <= head_ok_q[rd_dest];
					top_q                     <= top_q + VCNT_W'(1);
				end
			end
			if (cmd.bfs_pop) begin
				cur_ok_q <= head_ok_q[bfs_u];
				rd_q     <= rd_q + VCNT_W'(1);
			end
			if (cmd.bfs_edge) begin
				cur_ok_q <= rd_has_next;
				if (!rd_visited) begin
					visited_q[rd_dest] <= 1'b1;
					wr_q               <= wr_q + VCNT_W'(1);
				end
			end
			if (emit)
				emit_q <= emit_q + VCNT_W'(1);
			if (emit)
				pend_valid_q <= 1'b1;
			else if (cmd.flush)
				pend_valid_q <= 1'b0;
			if (push_out || cmd.flush)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cmd.clear) begin
				head_ok_q   <= '0;
				visited_q   <= '0;
				pool_used_q <= '0;
				drop_q      <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		sts.in_has_edge  = in_data.has_edge;
		sts.in_last      = in_data.last;
		sts.edge_bad     = edge_bad;
		sts.last_q       = last_q;
		sts.mode         = mode_q;
		sts.scan_done    = k_q > n_eff;
		sts.cand_visited = visited_q[cand];
		sts.top_zero     = top_q == '0;
		sts.top_ok       = ws_ok_q[tidx];
		sts.q_empty      = rd_q == wr_q;
		sts.cur_ok       = cur_ok_q;
		sts.rd_visited   = rd_visited;
		sts.out_busy     = out_valid_q && out_stall;
		sts.emit_done    = emit_q >= n_eff;
	end

endmodule

// ===== hw/rtl/graph_traversal_order_engine.sv =====
// Each input transaction carries one undirected edge (or a bare trigger) and is taken in the
// idle state; an edge that is linked into the pool then passes through the LINK_B and LINK_A
// states while input stalls. On a transaction marked last, the graph is walked breadth first
// or depth first from the start vertex, with unvisited vertices restarted in index order, and
// one output transaction per visited vertex is produced in visit order. Every adjacency entry
// is fetched through the single registered read port of the edge pool, the walk also steps
// through each restart candidate and each work store pop, and it waits on output stall. Each
// output trails its visit by one vertex; the last one leaves, flagged final, once the restart
// scan is through and the output is not held. Afterwards the graph, visited marks and drop
// counter clear in the CLEAR state.
module graph_traversal_order_engine
	import gtoe_pkg::*;
#(
	parameter int MAX_EDGES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	cmd_t   cmd;
	sts_t   sts;

	gtoe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gtoe_dp #(
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("more than one datapath command at once");

	a_all_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> sts.emit_done)
		else $error("traversal ended before every vertex was emitted");

	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_walk |-> !sts.out_busy)
		else $error("walk started while output register was held");

	a_walk_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dfs_edge || cmd.dfs_read) |-> sts.mode)
		else $error("depth first step while breadth first mode is set");

endmodule
